>>> rtl/core/status_frame_builder_macros.svh
// Assertion macros shared by the status frame builder checker.
`ifndef STATUS_FRAME_BUILDER_MACROS_SVH
`define STATUS_FRAME_BUILDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SFB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("status_frame_builder check failed");

// Next-cycle implication, disabled while reset is asserted
`define SFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("status_frame_builder check failed");

`endif

>>> rtl/core/sfb_pkg.sv
// Types and constants of the status frame builder.
`default_nettype none

package sfb_pkg;

    localparam int unsigned FRAME_LEN = 15;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned IN_W      = 72;

    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(FRAME_LEN - 1);
    localparam logic [7:0]       BYTE_START = 8'h7E;
    localparam logic [7:0]       BYTE_ID    = 8'h10;
    localparam logic [7:0]       DATA_LEN   = 8'd11;
    localparam logic [7:0]       BYTE_END   = 8'h0D;

    // Input item as packed on tdata: flags in the low byte
    typedef struct packed {
        logic [31:0] raw_value;
        logic [31:0] angle_value;
        logic [7:0]  flags;
    } t_item;

    // Whole frame, byte 0 sent first
    typedef logic [FRAME_LEN-1:0][7:0] t_frame;

endpackage

`default_nettype wire

>>> rtl/core/sfb_frame_build.sv
// Frame assembly: header, payload bytes and checksum from one item.
`default_nettype none

module sfb_frame_build (
    input  sfb_pkg::t_item  i_item,
    input  logic [7:0]      i_seq,
    output sfb_pkg::t_frame o_frame
);

    logic [7:0] w_angle_sum;
    logic [7:0] w_raw_sum;
    logic [7:0] w_head_sum;

    // Sum the length byte through the last raw byte, wrapping at 8 bits
    assign w_angle_sum = i_item.angle_value[7:0] + i_item.angle_value[15:8]
                       + i_item.angle_value[23:16] + i_item.angle_value[31:24];
    assign w_raw_sum   = i_item.raw_value[7:0] + i_item.raw_value[15:8]
                       + i_item.raw_value[23:16] + i_item.raw_value[31:24];
    assign w_head_sum  = sfb_pkg::DATA_LEN + i_seq + i_item.flags;

    // Lay out the frame bytes in send order
    always_comb begin
        o_frame     = '0;
        o_frame[0]  = sfb_pkg::BYTE_START;
        o_frame[1]  = sfb_pkg::BYTE_ID;
        o_frame[2]  = sfb_pkg::DATA_LEN;
        o_frame[3]  = i_seq;
        o_frame[4]  = i_item.flags;
        for (int k = 0; k < 4; k++) begin
            o_frame[5 + k] = i_item.angle_value[8*k +: 8];
            o_frame[9 + k] = i_item.raw_value[8*k +: 8];
        end
        o_frame[13] = w_head_sum + w_angle_sum + w_raw_sum;
        o_frame[14] = sfb_pkg::BYTE_END;
    end

endmodule

`default_nettype wire

>>> rtl/core/status_frame_builder.sv
// Top level of the status frame builder: item buffer, frame serializer, output register.
//
//  Channel   Direction  tdata                                   tlast
//  s (item)  in         72 bits: flags[7:0], angle, raw         -
//  m (byte)  out        8 bits: frame_byte                      frame_last
//
// Each item becomes 15 output transactions, one frame byte per cycle while the output is not stalled.
// The sustained item rate is set by the one-byte output port.
// A second item waits in the input buffer while a frame is sent; the next
// frame is loaded in the same cycle as the end byte of the previous one goes to the output register.
// Reset (synchronous, active low) clears the valid flags and the sequence count.
// Output stalls hold the output register and the serializer byte index.
`default_nettype none

module status_frame_builder (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [sfb_pkg::IN_W-1:0] i_s_tdata,   // flag_valid, flag_position_error,
                                                  // flag_crc_error, flag_read_status,
                                                  // flag_busy, flag_done, flag_power,
                                                  // flag_manual, angle_value[31:0],
                                                  // raw_value[31:0]
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [7:0]               o_m_tdata,   // frame_byte[7:0]
    output logic                     o_m_tlast    // frame_last
);

    logic                      r_in_full;
    sfb_pkg::t_item            r_in_item;
    logic                      r_ser_busy;
    logic [sfb_pkg::IDX_W-1:0] r_idx;
    sfb_pkg::t_frame           r_frame;
    logic [7:0]                r_seq;
    logic                      r_out_valid;
    logic [7:0]                r_out_data;
    logic                      r_out_last;

    sfb_pkg::t_frame           w_frame;
    logic                      w_s_accept;
    logic                      w_step;
    logic                      w_ser_done;
    logic                      w_ser_load;

    // Handshake decisions
    assign o_s_tready = !r_in_full;
    assign w_s_accept = i_s_tvalid && !r_in_full;
    assign w_step     = r_ser_busy && (!r_out_valid || i_m_tready);
    assign w_ser_done = w_step && (r_idx == sfb_pkg::LAST_IDX);
    assign w_ser_load = r_in_full && (!r_ser_busy || w_ser_done);

    sfb_frame_build u_build (
        .i_item  (r_in_item),
        .i_seq   (r_seq),
        .o_frame (w_frame)
    );

    // Hold the next item until the serializer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_full <= 1'b0;
        end else begin
            r_in_full <= (r_in_full && !w_ser_load) || w_s_accept;
        end
        if (w_s_accept) begin
            r_in_item <= sfb_pkg::t_item'(i_s_tdata);
        end
    end

    // Load a frame, advance one byte per output slot, bump the sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_busy <= 1'b0;
            r_idx      <= '0;
            r_seq      <= '0;
        end else if (w_ser_load) begin
            r_ser_busy <= 1'b1;
            r_idx      <= '0;
            r_seq      <= r_seq + 8'd1;
        end else if (w_ser_done) begin
            r_ser_busy <= 1'b0;
            r_idx      <= '0;
        end else if (w_step) begin
            r_idx      <= r_idx + 1'b1;
        end
        if (w_ser_load) begin
            r_frame <= w_frame;
        end
    end

    // Output register: fill on a step, drop after the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_step) begin
            r_out_data <= r_frame[r_idx];
            r_out_last <= (r_idx == sfb_pkg::LAST_IDX);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

>>> rtl/core/sfb_checker.sv
// Port-level checks of the status frame builder, bound to the top level.
`default_nettype none

`include "status_frame_builder_macros.svh"

module sfb_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_s_tvalid,
    input logic                     o_s_tready,
    input logic [sfb_pkg::IN_W-1:0] i_s_tdata,
    input logic                     o_m_tvalid,
    input logic                     i_m_tready,
    input logic [7:0]               o_m_tdata,
    input logic                     o_m_tlast
);

    logic [sfb_pkg::IDX_W-1:0] r_pos;
    logic                      w_m_xfer;
    logic                      w_s_xfer;

    assign w_m_xfer = o_m_tvalid && i_m_tready;
    assign w_s_xfer = i_s_tvalid && o_s_tready;

    // Track the byte position within the current frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_m_xfer) begin
            r_pos <= o_m_tlast ? '0 : r_pos + 1'b1;
        end
    end

    `SFB_ASSERT_NOW(a_last_at_end, o_m_tvalid, o_m_tlast == (r_pos == sfb_pkg::LAST_IDX))
    `SFB_ASSERT_NOW(a_start_byte, o_m_tvalid && r_pos == '0, o_m_tdata == sfb_pkg::BYTE_START)
    `SFB_ASSERT_NOW(a_end_byte, o_m_tvalid && o_m_tlast, o_m_tdata == sfb_pkg::BYTE_END)
    `SFB_ASSERT_NEXT(a_hold_stall, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    `SFB_ASSERT_NEXT(a_buffer_full, w_s_xfer, !o_s_tready)

endmodule

bind status_frame_builder sfb_checker u_sfb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
